/* hw/rtl/sle_pkg.sv */
// Shared types and constants for the sequential list engine.
// No dependencies; sle_ctrl, the top level and the testbench import this package.
package sle_pkg;

	localparam int CAPACITY_DEF = 64;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOCATE = 2'd2,
		OP_APPEND = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOVE,
		S_DRAIN,
		S_PUT,
		S_SCAN,
		S_SCAN_LAST,
		S_FINISH
	} state_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] position;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		stat_t      status;
		logic [6:0] found_position;
		logic [6:0] list_length_out;
	} rsp_t;

endpackage

/* hw/rtl/sle_store.sv */
// Element store of the sequential list engine: one write port, one read port
// with registered read data. Depends on nothing but its parameter.
module sle_store #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [7:0]               rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/sle_ctrl.sv */
// Sequencer of the sequential list engine: request decode, list length,
// and the shared cursor step and compare unit that drives the store.
// Depends on sle_pkg.
module sle_ctrl
	import sle_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  req_t                        req,
	output logic                        req_stall,
	input  logic                        out_free,
	output logic                        res_load,
	output rsp_t                        res,
	output logic                        mem_wr_en,
	output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
	output logic [7:0]                  mem_wr_data,
	output logic                        mem_rd_en,
	output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
	input  logic [7:0]                  mem_rd_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int PW = ((LW > 8) ? LW : 8) + 1;
	localparam int XW = (LW > 7) ? LW : 7;

	state_t        state_q, state_d;
	logic [LW-1:0] len_q;
	logic          pend_q;
	op_t           op_q;
	logic [7:0]    val_q;
	logic [AW-1:0] rd_q, end_q, prev_q, wr_q;
	stat_t         status_q;
	logic [6:0]    found_q;

	logic [PW-1:0] pos_x, len_x;
	logic          accept, ins_bad, del_bad, is_full, ins_tail, del_tail, len_zero;
	logic          direct_wr, del_now;
	logic [AW-1:0] rd_step;
	logic          at_end, match;
	logic [XW-1:0] found_x, len_out_x;

	assign pos_x    = PW'(req.position);
	assign len_x    = PW'(len_q);
	assign accept   = req_valid && (state_q == S_IDLE);
	assign ins_bad  = (pos_x == '0) || (pos_x > len_x + PW'(1));
	assign del_bad  = (pos_x == '0) || (pos_x > len_x);
	assign is_full  = (len_q == LW'(CAPACITY));
	assign ins_tail = (pos_x == len_x + PW'(1));
	assign del_tail = (pos_x == len_x);
	assign len_zero = (len_q == '0);

	assign direct_wr = accept && !is_full &&
		(((req.operation == OP_INSERT) && !ins_bad && ins_tail) ||
		 (req.operation == OP_APPEND));
	assign del_now = accept && (req.operation == OP_DELETE) && !del_bad && del_tail;

	assign rd_step   = (op_q == OP_INSERT) ? (rd_q - AW'(1)) : (rd_q + AW'(1));
	assign at_end    = (rd_q == end_q);
	assign match     = (mem_rd_data == val_q);
	assign found_x   = XW'(prev_q) + XW'(1);
	assign len_out_x = XW'(len_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.operation)
						OP_INSERT: begin
							if (ins_bad || is_full || ins_tail) begin
								state_d = S_FINISH;
							end else begin
								state_d = S_MOVE;
							end
						end
						OP_DELETE: begin
							if (del_bad || del_tail) begin
								state_d = S_FINISH;
							end else begin
								state_d = S_MOVE;
							end
						end
						OP_LOCATE: begin
							state_d = len_zero ? S_FINISH : S_SCAN;
						end
						OP_APPEND: begin
							state_d = S_FINISH;
						end
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_MOVE: begin
				if (at_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = (op_q == OP_INSERT) ? S_PUT : S_FINISH;
			end
			S_PUT: begin
				state_d = S_FINISH;
			end
			S_SCAN: begin
				priority if (pend_q && match) begin
					state_d = S_FINISH;
				end else if (at_end) begin
					state_d = S_SCAN_LAST;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN_LAST: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = wr_q;
		mem_wr_data = mem_rd_data;
		mem_rd_en   = 1'b0;
		mem_rd_addr = rd_q;
		unique case (state_q)
			S_IDLE: begin
				mem_wr_en   = direct_wr;
				mem_wr_addr = AW'(len_q);
				mem_wr_data = req.value;
			end
			S_MOVE: begin
				mem_wr_en = pend_q;
				mem_rd_en = 1'b1;
			end
			S_DRAIN: begin
				mem_wr_en = 1'b1;
			end
			S_PUT: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = end_q;
				mem_wr_data = val_q;
			end
			S_SCAN: begin
				mem_rd_en = 1'b1;
			end
			S_SCAN_LAST, S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	assign req_stall           = (state_q != S_IDLE);
	assign res_load            = (state_q == S_FINISH) && out_free;
	assign res.status          = status_q;
	assign res.found_position  = found_q;
	assign res.list_length_out = len_out_x[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pend_q <= 1'b0;
			end else if ((state_q == S_MOVE) || (state_q == S_SCAN)) begin
				pend_q <= 1'b1;
			end
			priority if (direct_wr || (state_q == S_PUT)) begin
				len_q <= len_q + LW'(1);
			end else if (del_now || ((state_q == S_DRAIN) && (op_q == OP_DELETE))) begin
				len_q <= len_q - LW'(1);
			end else begin
				len_q <= len_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			val_q   <= req.value;
			found_q <= '0;
			unique case (req.operation)
				OP_INSERT: begin
					status_q <= ins_bad ? ST_RANGE : (is_full ? ST_FULL : ST_OK);
					rd_q     <= AW'(len_q - LW'(1));
					end_q    <= AW'(pos_x - PW'(1));
					prev_q   <= AW'(len_q);
				end
				OP_DELETE: begin
					status_q <= del_bad ? ST_RANGE : ST_OK;
					rd_q     <= AW'(pos_x);
					end_q    <= AW'(len_q - LW'(1));
					prev_q   <= AW'(pos_x - PW'(1));
				end
				OP_LOCATE: begin
					status_q <= ST_OK;
					rd_q     <= '0;
					end_q    <= AW'(len_q - LW'(1));
				end
				OP_APPEND: begin
					status_q <= is_full ? ST_FULL : ST_OK;
				end
				default: status_q <= ST_OK;
			endcase
		end else if ((state_q == S_MOVE) || (state_q == S_SCAN)) begin
			rd_q   <= rd_step;
			prev_q <= rd_q;
			wr_q   <= prev_q;
			if ((state_q == S_SCAN) && pend_q && match) begin
				found_q <= found_x[6:0];
			end
		end else if ((state_q == S_SCAN_LAST) && match) begin
			found_q <= found_x[6:0];
		end
	end

`ifndef SYNTHESIS
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAPACITY))
		else $error("list length beyond capacity");

	a_drain_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN || state_q == S_SCAN_LAST) |-> pend_q)
		else $error("drain without a pending read");

	a_found_locate: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && op_q != OP_LOCATE) |-> (found_q == '0))
		else $error("found position set outside locate");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (state_q == S_IDLE))
		else $error("sequencer not idle after result");
`endif

endmodule

/* hw/rtl/sequential_list_engine.sv */
// Sequential list engine: an ordered list of up to CAPACITY bytes kept in one
// single-port-write, single-port-read store and worked on one request at a
// time. Append, insert or delete at the tail, and any request refused for
// range or a full list, write at acceptance if at all and go straight to
// the finish state. Insert and delete move one element per cycle through
// the store's read and write ports; locate reads one element per cycle.
// The store needs no clearing pass after reset.
// A finished result waits in an output register; the next request is taken
// once the sequencer is idle again.
// Top level; depends on sle_pkg, sle_store and sle_ctrl.
module sequential_list_engine
	import sle_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic          out_free, res_load;
	rsp_t          res;
	logic          mem_wr_en, mem_rd_en;
	logic [AW-1:0] mem_wr_addr, mem_rd_addr;
	logic [7:0]    mem_wr_data, mem_rd_data;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	sle_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req        (req),
		.req_stall  (req_stall),
		.out_free   (out_free),
		.res_load   (res_load),
		.res        (res),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	sle_store #(
		.DEPTH(CAPACITY)
	) u_store (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sequential_list_engine: directed and random list
// requests, predicted in-line against a local copy of the list. Depends on sle_pkg.
module testbench;
	import sle_pkg::*;

	localparam int CAP = CAPACITY_DEF;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic [7:0] list_model [0:CAP-1];
	int list_len;
	rsp_t rsp_due[$];
	rsp_t want;
	logic calm = 1'b0;
	int errors;
	int requests;
	int results;
	int range_refusals;
	int full_refusals;
	int locate_hits;

	sequential_list_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		errors++;
		if (errors <= 20)
			$display("mismatch at result %0d: %s", results, msg);
	endtask

	function automatic rsp_t apply_list_op(input req_t r);
		rsp_t o;
		int p;
		int k;
		p = int'(r.position);
		o.status = ST_OK;
		o.found_position = '0;
		case (r.operation)
			OP_INSERT: begin
				if (p < 1 || p > list_len + 1) begin
					o.status = ST_RANGE;
				end else if (list_len >= CAP) begin
					o.status = ST_FULL;
				end else begin
					for (k = list_len; k >= p; k--)
						list_model[k] = list_model[k-1];
					list_model[p-1] = r.value;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (p < 1 || p > list_len) begin
					o.status = ST_RANGE;
				end else begin
					for (k = p; k < list_len; k++)
						list_model[k-1] = list_model[k];
					list_len--;
				end
			end
			OP_LOCATE: begin
				for (k = 0; k < list_len; k++)
					if (o.found_position == 0 && list_model[k] == r.value)
						o.found_position = 7'(k + 1);
			end
			default: begin
				if (list_len >= CAP) begin
					o.status = ST_FULL;
				end else begin
					list_model[list_len] = r.value;
					list_len++;
				end
			end
		endcase
		o.list_length_out = 7'(list_len);
		return o;
	endfunction

	task automatic issue_request(input op_t op, input logic [7:0] pos, input logic [7:0] val);
		rsp_t r;
		while (!calm && $urandom_range(99) < 14) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{op, pos, val};
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		r = apply_list_op('{op, pos, val});
		requests++;
		if (r.status == ST_RANGE)
			range_refusals++;
		if (r.status == ST_FULL)
			full_refusals++;
		if (r.found_position != 0)
			locate_hits++;
		rsp_due.push_back(r);
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (rsp_due.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 14);
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due.size() == 0) begin
				flag_mismatch("result with no request pending");
			end else begin
				want = rsp_due.pop_front();
				if (rsp.status !== want.status)
					flag_mismatch($sformatf("status %0d, want %0d",
						rsp.status, want.status));
				if (rsp.found_position !== want.found_position)
					flag_mismatch($sformatf("found_position %0d, want %0d",
						rsp.found_position, want.found_position));
				if (rsp.list_length_out !== want.list_length_out)
					flag_mismatch($sformatf("list_length_out %0d, want %0d",
						rsp.list_length_out, want.list_length_out));
			end
			results++;
		end
	end

	task automatic test_empty_list();
		issue_request(OP_LOCATE, 8'd0, 8'd0);
		issue_request(OP_DELETE, 8'd0, 8'd0);
		issue_request(OP_DELETE, 8'd1, 8'hFF);
		issue_request(OP_INSERT, 8'd0, 8'h11);
		issue_request(OP_INSERT, 8'd2, 8'h22);
		issue_request(OP_INSERT, 8'd255, 8'h33);
	endtask

	task automatic test_edit_and_locate();
		issue_request(OP_INSERT, 8'd1, 8'hFF);
		issue_request(OP_APPEND, 8'hFF, 8'h00);
		issue_request(OP_INSERT, 8'd2, 8'h5A);
		issue_request(OP_INSERT, 8'd4, 8'h81);
		issue_request(OP_LOCATE, 8'hAA, 8'hFF);
		issue_request(OP_LOCATE, 8'd0, 8'h00);
		issue_request(OP_LOCATE, 8'd0, 8'h81);
		issue_request(OP_LOCATE, 8'd0, 8'h33);
		issue_request(OP_DELETE, 8'd5, 8'd0);
		issue_request(OP_DELETE, 8'd1, 8'd0);
		issue_request(OP_DELETE, 8'd3, 8'd0);
		issue_request(OP_DELETE, 8'd0, 8'd0);
	endtask

	task automatic test_full_list();
		while (list_len < CAP)
			issue_request(OP_APPEND, 8'($urandom), 8'($urandom_range(0, 15)));
		issue_request(OP_APPEND, 8'd0, 8'h77);
		issue_request(OP_INSERT, 8'd1, 8'h77);
		issue_request(OP_INSERT, 8'(CAP + 1), 8'h77);
		issue_request(OP_INSERT, 8'(CAP + 2), 8'h77);
		issue_request(OP_DELETE, 8'(CAP + 1), 8'h00);
		issue_request(OP_LOCATE, 8'd0, list_model[CAP-1]);
		issue_request(OP_LOCATE, 8'd0, 8'hEE);
		issue_request(OP_DELETE, 8'(CAP), 8'h00);
		while (list_len > 0)
			issue_request(OP_DELETE, 8'($urandom_range(1, list_len)), 8'($urandom));
	endtask

	task automatic test_random_ops(input int count);
		op_t op;
		logic [7:0] pos;
		logic [7:0] val;
		int r;
		int grow;
		for (int i = 0; i < count; i++) begin
			calm = (i >= 500 && i < 750);
			if (i == count / 2)
				wait_for_results();
			grow = ((i / 120) % 2) == 0;
			r = $urandom_range(99);
			if (grow)
				op = r < 40 ? OP_INSERT : r < 70 ? OP_APPEND : r < 85 ? OP_DELETE : OP_LOCATE;
			else
				op = r < 15 ? OP_INSERT : r < 25 ? OP_APPEND : r < 75 ? OP_DELETE : OP_LOCATE;
			if ($urandom_range(99) < 85)
				pos = 8'($urandom_range(0, list_len + 1));
			else
				pos = 8'($urandom);
			r = $urandom_range(99);
			if (op == OP_LOCATE && list_len > 0 && r < 60)
				val = list_model[$urandom_range(0, list_len - 1)];
			else if (r < 80)
				val = 8'($urandom_range(0, 7));
			else
				val = 8'($urandom);
			issue_request(op, pos, val);
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		list_len = 0;
		errors = 0;
		requests = 0;
		results = 0;
		range_refusals = 0;
		full_refusals = 0;
		locate_hits = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_edit_and_locate();
		test_full_list();
		test_random_ops(1500);
		wait_for_results();
		repeat (CAP + 8) @(posedge clk);
		$display("covered %0d requests, %0d results checked", requests, results);
		$display("range refusals %0d, full refusals %0d, locate hits %0d",
			range_refusals, full_refusals, locate_hits);
		if (errors == 0 && rsp_due.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results pending", rsp_due.size());
		$display("testbench: done, errors");
		$finish;
	end

endmodule
